// File: sv/twi_master_transaction_sequencer_top_assert.svh
// assertion macros for the two-wire master sequencer
`ifndef TWI_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH
`define TWI_MASTER_TRANSACTION_SEQUENCER_TOP_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TWMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define TWMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/twms_pkg.sv
// types and constants shared by the two-wire master sequencer
package twms_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int ADDR_W    = $clog2(BUF_DEPTH);

    localparam logic [7:0] STATUS_MASK = 8'hFC;
    localparam logic [7:0] NO_STATUS   = 8'hF8;

    localparam logic [7:0] ST_START     = 8'h08;
    localparam logic [7:0] ST_RESTART   = 8'h10;
    localparam logic [7:0] ST_ADDR_ACK  = 8'h18;
    localparam logic [7:0] ST_DATA_ACK  = 8'h28;
    localparam logic [7:0] ST_ARB_LOST  = 8'h38;
    localparam logic [7:0] ST_RX_ADDR   = 8'h40;
    localparam logic [7:0] ST_RX_ACK    = 8'h50;
    localparam logic [7:0] ST_RX_NACK   = 8'h58;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_START = 2'd1,
        MODE_EVENT = 2'd2,
        MODE_READ  = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode      mode;
        logic [6:0] index;
        logic [7:0] value;
        logic [6:0] dev_address;
        logic       read_not_write;
        logic [7:0] length;
        logic [7:0] status;
    } t_in_beat;

    typedef struct packed {
        logic       ctl_write;
        logic       ctl_start;
        logic       ctl_stop;
        logic       ctl_ack;
        logic       ctl_int_enable;
        logic       data_load;
        logic [7:0] data_out;
        logic       busy_res;
        logic       transfer_ok;
        logic [7:0] fail_status;
        logic [7:0] read_value;
    } t_out_beat;

endpackage

// File: sv/twms_if.sv
// valid/ready channels for the sequencer item and result beats
interface twms_in_if;
    import twms_pkg::*;
    logic     valid;
    logic     ready;
    t_in_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface twms_out_if;
    import twms_pkg::*;
    logic      valid;
    logic      ready;
    t_out_beat payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: sv/twi_master_transaction_sequencer_top.sv
// two-wire bus master transaction sequencer, top level
//
// i_req carries one item per beat: buffer load, transaction start, bus status
// event or buffer read. o_rsp returns exactly one result beat per item, with
// the control command for the byte engine, the byte to transmit, the busy and
// completion flags, the stored failure status and the byte read back.
// an item taken sits in the input register; its result is registered when
// o_rsp is not stalled. one item per cycle is sustained while o_rsp is not
// stalled; the frame buffer is a single ram read at the item register stage,
// and its registered read data feeds data_out and read_value directly.
// i_rst_n low clears the pointer, length, flags and both valid bits and sets
// the failure status to 0xf8; buffer contents are not cleared.
// when o_rsp is stalled the result and ram read data hold, the input register
// still takes one more item, and then i_req.ready drops until the result beat
// is taken.
module twi_master_transaction_sequencer_top (
    input logic        i_clk,
    input logic        i_rst_n,
    twms_in_if.sink    i_req,
    twms_out_if.source o_rsp
);
    import twms_pkg::*;

    logic              r_s1_valid;
    t_in_beat          r_s1;
    logic              r_out_valid;
    t_out_beat         r_res;
    logic              r_sel_dl;
    logic              r_sel_rd;

    logic [7:0]        r_ptr;
    logic [7:0]        r_len;
    logic              r_ok;
    logic              r_busy;
    logic [7:0]        r_fail;

    logic [7:0]        n_ptr;
    logic [7:0]        n_len;
    logic              n_ok;
    logic              n_busy;
    logic [7:0]        n_fail;
    t_out_beat         n_res;
    logic              n_sel_rd;

    logic              w_adv;
    logic              w_fire;
    logic [7:0]        w_st;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] w_raddr;
    logic [7:0]        w_rdata;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign w_fire      = r_s1_valid && w_adv;
    assign i_req.ready = !r_s1_valid || w_adv;
    assign w_st        = r_s1.status & STATUS_MASK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1 <= i_req.payload;
        end
    end

    always_comb begin
        logic [7:0] v_ptr;
        logic [8:0] v_inc;
        v_ptr    = r_ptr;
        v_inc    = '0;
        n_ptr    = r_ptr;
        n_len    = r_len;
        n_ok     = r_ok;
        n_busy   = r_busy;
        n_fail   = r_fail;
        n_res    = '0;
        n_sel_rd = 1'b0;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wdata  = '0;
        w_re     = 1'b0;
        w_raddr  = '0;

        unique case (r_s1.mode)
            MODE_LOAD: begin
                if ({2'b00, r_s1.index} < 9'(BUF_DEPTH)) begin
                    w_we    = 1'b1;
                    w_waddr = ADDR_W'(r_s1.index);
                    w_wdata = r_s1.value;
                end
            end
            MODE_START: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = {r_s1.dev_address, r_s1.read_not_write};
                n_len   = ({1'b0, r_s1.length} > 9'(BUF_DEPTH)) ? 8'(BUF_DEPTH)
                                                               : r_s1.length;
                n_ok    = 1'b0;
                n_fail  = NO_STATUS;
                n_busy  = 1'b1;
                n_res.ctl_write      = 1'b1;
                n_res.ctl_start      = 1'b1;
                n_res.ctl_int_enable = 1'b1;
            end
            MODE_EVENT: begin
                if (r_busy) begin
                    n_res.ctl_write = 1'b1;
                    unique case (w_st)
                        ST_START, ST_RESTART, ST_ADDR_ACK, ST_DATA_ACK: begin
                            if (w_st == ST_START || w_st == ST_RESTART) begin
                                v_ptr = '0;
                            end
                            n_ptr = v_ptr;
                            if (v_ptr < r_len) begin
                                w_re    = 1'b1;
                                w_raddr = ADDR_W'(v_ptr);
                                n_ptr   = (v_ptr == 8'hFF) ? v_ptr : v_ptr + 8'd1;
                                n_res.data_load      = 1'b1;
                                n_res.ctl_int_enable = 1'b1;
                            end else begin
                                n_ok   = 1'b1;
                                n_busy = 1'b0;
                                n_res.ctl_stop = 1'b1;
                            end
                        end
                        ST_RX_ACK, ST_RX_ADDR: begin
                            if (w_st == ST_RX_ACK) begin
                                if ({1'b0, r_ptr} < 9'(BUF_DEPTH)) begin
                                    w_we    = 1'b1;
                                    w_waddr = ADDR_W'(r_ptr);
                                    w_wdata = r_s1.value;
                                end
                                v_ptr = (r_ptr == 8'hFF) ? r_ptr : r_ptr + 8'd1;
                            end
                            n_ptr = v_ptr;
                            v_inc = {1'b0, v_ptr} + 9'd1;
                            n_res.ctl_int_enable = 1'b1;
                            n_res.ctl_ack        = v_inc < {1'b0, r_len};
                        end
                        ST_RX_NACK: begin
                            if ({1'b0, r_ptr} < 9'(BUF_DEPTH)) begin
                                w_we    = 1'b1;
                                w_waddr = ADDR_W'(r_ptr);
                                w_wdata = r_s1.value;
                            end
                            n_ok   = 1'b1;
                            n_busy = 1'b0;
                            n_res.ctl_stop = 1'b1;
                        end
                        ST_ARB_LOST: begin
                            n_res.ctl_start      = 1'b1;
                            n_res.ctl_int_enable = 1'b1;
                        end
                        default: begin
                            n_fail = w_st;
                            n_busy = 1'b0;
                        end
                    endcase
                end
            end
            MODE_READ: begin
                if ({2'b00, r_s1.index} < 9'(BUF_DEPTH)) begin
                    w_re     = 1'b1;
                    w_raddr  = ADDR_W'(r_s1.index);
                    n_sel_rd = 1'b1;
                end
            end
            default: begin
            end
        endcase

        n_res.busy_res    = n_busy;
        n_res.transfer_ok = n_ok;
        n_res.fail_status = n_fail;
    end

    twms_ram #(
        .WIDTH (8),
        .DEPTH (BUF_DEPTH)
    ) u_frame_buf (
        .i_clk   (i_clk),
        .i_we    (w_fire && w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_fire && w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
            r_len       <= '0;
            r_ok        <= 1'b0;
            r_busy      <= 1'b0;
            r_fail      <= NO_STATUS;
        end else begin
            if (w_adv) begin
                r_out_valid <= r_s1_valid;
            end
            if (w_fire) begin
                r_ptr  <= n_ptr;
                r_len  <= n_len;
                r_ok   <= n_ok;
                r_busy <= n_busy;
                r_fail <= n_fail;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res    <= n_res;
            r_sel_dl <= n_res.data_load;
            r_sel_rd <= n_sel_rd;
        end
    end

    assign o_rsp.valid = r_out_valid;

    always_comb begin
        o_rsp.payload            = r_res;
        o_rsp.payload.data_out   = r_sel_dl ? w_rdata : 8'd0;
        o_rsp.payload.read_value = r_sel_rd ? w_rdata : 8'd0;
    end

    `include "twi_master_transaction_sequencer_top_assert.svh"

    `TWMS_ASSERT_NOW(a_len_bound, 1'b1, {1'b0, r_len} <= 9'(BUF_DEPTH), "frame length over depth")
    `TWMS_ASSERT_NOW(a_stop_idle, r_out_valid && r_res.ctl_stop, !r_res.busy_res, "stop while busy")
    `TWMS_ASSERT_NOW(a_load_cmd, r_out_valid && r_res.data_load, r_res.ctl_write && r_res.ctl_int_enable, "data load without command")
    `TWMS_ASSERT_NOW(a_quiet_cmd, r_out_valid && !r_res.ctl_write, !(r_res.ctl_start || r_res.ctl_stop || r_res.ctl_ack || r_res.ctl_int_enable), "control flags without write")
    `TWMS_ASSERT_NEXT(a_start_busy, w_fire && r_s1.mode == MODE_START, r_busy && !r_ok, "start did not set busy")

endmodule

// File: sv/twms_ram.sv
// generic single-write, single-read ram with registered read data
module twms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
